>>> hdl/ordered_value_list_core_defines.svh
// ============================================================================
// ordered_value_list_core_defines: assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ============================================================================
`ifndef ORDERED_VALUE_LIST_CORE_DEFINES_SVH
`define ORDERED_VALUE_LIST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk_i, off during reset.
`define OVL_ASSERT(label_, ante_, cons_, msg_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |-> (cons_)) \
    else $error(msg_);
// Next-cycle implication, clocked on clk_i, off during reset.
`define OVL_ASSERT_NEXT(label_, ante_, cons_, msg_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |=> (cons_)) \
    else $error(msg_);
`else
`define OVL_ASSERT(label_, ante_, cons_, msg_)
`define OVL_ASSERT_NEXT(label_, ante_, cons_, msg_)
`endif

`endif

>>> hdl/ovl_pkg.sv
// ============================================================================
// ovl_pkg
// Shared types for the ordered value list: payloads, codes, control and
// status bundles between controller and datapath.
// ============================================================================
`timescale 1ns / 1ps

package ovl_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_MODIFY  = 2'd2,
    CMD_DISPLAY = 2'd3
  } ovl_cmd_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ENTRY     = 3'd4
  } ovl_status_e;

  // Store write port source
  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_INSERT = 2'd1,
    WR_MODIFY = 2'd2,
    WR_SHIFT  = 2'd3
  } ovl_wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } ovl_cnt_op_e;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] new_value;
  } ovl_in_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [DataW-1:0] entry_value;
    logic                    last;
  } ovl_out_t;

  // Controller -> datapath
  typedef struct packed {
    logic        in_ready;
    logic        start_scan;
    logic        advance;
    ovl_wr_sel_e wr_sel;
    ovl_cnt_op_e cnt_op;
    logic        res_load;
    ovl_status_e res_status;
    logic        res_last;
  } ovl_ctl_t;

  // Datapath -> controller
  typedef struct packed {
    ovl_cmd_e cmd;
    logic     empty;
    logic     full;
    logic     rd_valid;
    logic     match;
    logic     at_last;
    logic     out_free;
  } ovl_stat_t;

endpackage

>>> hdl/ovl_dp.sv
// ============================================================================
// ovl_dp
// Datapath: value store, entry count, scan read pipeline, output register.
// ============================================================================
`timescale 1ns / 1ps

module ovl_dp import ovl_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_accept_i,
  input  ovl_in_t   in_item_i,
  input  ovl_ctl_t  ctl_i,
  input  logic      out_stall_i,
  output ovl_stat_t stat_o,
  output logic      out_valid_o,
  output ovl_out_t  out_item_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [DataW-1:0] store_q [DEPTH];

  ovl_cmd_e                cmd_q;
  logic signed [DataW-1:0] value_q;
  logic signed [DataW-1:0] new_value_q;
  logic [CW-1:0]           count_q;
  logic [CW-1:0]           idx_q;
  logic                    rd_valid_q;
  logic [AW-1:0]           rd_pos_q;
  logic signed [DataW-1:0] rdata_q;
  logic                    out_valid_q;
  ovl_out_t                out_q;

  logic                    issue;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [DataW-1:0] wr_data;
  logic [CW-1:0]           last_pos;
  logic                    out_free;

  assign issue    = ctl_i.advance && (idx_q < count_q);
  assign last_pos = CW'(count_q - CW'(1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = rd_pos_q;
    wr_data = rdata_q;
    case (ctl_i.wr_sel)
      WR_INSERT: begin
        wr_addr = count_q[AW-1:0];
        wr_data = value_q;
      end
      WR_MODIFY: begin
        wr_addr = rd_pos_q;
        wr_data = new_value_q;
      end
      WR_SHIFT: begin
        // entry moves down one address
        wr_addr = AW'(rd_pos_q - AW'(1));
        wr_data = rdata_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Store: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata_q <= store_q[idx_q[AW-1:0]];
    end
  end

  // Item fields and read position
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      cmd_q       <= ovl_cmd_e'(in_item_i.cmd);
      value_q     <= in_item_i.value;
      new_value_q <= in_item_i.new_value;
    end
    if (ctl_i.advance) begin
      rd_pos_q <= idx_q[AW-1:0];
    end
    if (ctl_i.res_load) begin
      out_q.status      <= ctl_i.res_status;
      out_q.entry_value <= (ctl_i.res_status == ST_ENTRY) ? rdata_q : '0;
      out_q.last        <= ctl_i.res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (ctl_i.cnt_op)
        CNT_INC: count_q <= CW'(count_q + CW'(1));
        CNT_DEC: count_q <= CW'(count_q - CW'(1));
        default: count_q <= count_q;
      endcase

      if (ctl_i.start_scan) begin
        idx_q      <= '0;
        rd_valid_q <= 1'b0;
      end else if (ctl_i.advance) begin
        if (issue) begin
          idx_q <= CW'(idx_q + CW'(1));
        end
        rd_valid_q <= issue;
      end

      if (ctl_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == CW'(DEPTH));
  assign stat_o.rd_valid = rd_valid_q;
  assign stat_o.match    = (rdata_q == value_q);
  assign stat_o.at_last  = (CW'(rd_pos_q) == last_pos);
  assign stat_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> hdl/ovl_ctrl.sv
// ============================================================================
// ovl_ctrl
// Command sequencer: decode, scan, shift-down and result issue.
// ============================================================================
`timescale 1ns / 1ps

module ovl_ctrl import ovl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_accept_i,
  input  ovl_stat_t stat_i,
  output ovl_ctl_t  ctl_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECODE = 2'd1,
    S_SCAN   = 2'd2,
    S_SHIFT  = 2'd3
  } state_e;

  state_e   state_q, state_d;
  ovl_ctl_t ctl;
  logic     step;

  // pipeline moves unless a read result waits on a full output slot
  assign step = !stat_i.rd_valid || stat_i.out_free;

  always_comb begin
    state_d        = state_q;
    ctl            = '0;
    ctl.wr_sel     = WR_NONE;
    ctl.cnt_op     = CNT_HOLD;
    ctl.res_status = ST_DONE;
    case (state_q)
      S_IDLE: begin
        ctl.in_ready = stat_i.out_free;
        if (in_accept_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.out_free) begin
          if (stat_i.cmd == CMD_INSERT) begin
            ctl.res_load = 1'b1;
            ctl.res_last = 1'b1;
            if (stat_i.full) begin
              ctl.res_status = ST_FULL;
            end else begin
              ctl.wr_sel = WR_INSERT;
              ctl.cnt_op = CNT_INC;
            end
            state_d = S_IDLE;
          end else if (stat_i.empty) begin
            ctl.res_load   = 1'b1;
            ctl.res_last   = 1'b1;
            ctl.res_status = ST_EMPTY;
            state_d        = S_IDLE;
          end else begin
            ctl.start_scan = 1'b1;
            state_d        = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctl.advance = step;
        if (stat_i.rd_valid && step) begin
          case (stat_i.cmd)
            CMD_DISPLAY: begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ST_ENTRY;
              ctl.res_last   = stat_i.at_last;
              if (stat_i.at_last) begin
                state_d = S_IDLE;
              end
            end
            CMD_DELETE: begin
              if (stat_i.match) begin
                state_d = S_SHIFT;
              end else if (stat_i.at_last) begin
                ctl.res_load   = 1'b1;
                ctl.res_last   = 1'b1;
                ctl.res_status = ST_NOT_FOUND;
                state_d        = S_IDLE;
              end
            end
            CMD_MODIFY: begin
              ctl.res_load = 1'b1;
              ctl.res_last = 1'b1;
              if (stat_i.match) begin
                ctl.wr_sel = WR_MODIFY;
                state_d    = S_IDLE;
              end else if (stat_i.at_last) begin
                ctl.res_status = ST_NOT_FOUND;
                state_d        = S_IDLE;
              end else begin
                ctl.res_load = 1'b0;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SHIFT: begin
        if (stat_i.rd_valid) begin
          ctl.advance = 1'b1;
          ctl.wr_sel  = WR_SHIFT;
        end else if (stat_i.out_free) begin
          ctl.cnt_op   = CNT_DEC;
          ctl.res_load = 1'b1;
          ctl.res_last = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctl_o = ctl;

endmodule

>>> hdl/ordered_value_list_core.sv
// ============================================================================
// ordered_value_list_core
// Ordered list of up to DEPTH signed 32-bit values with insert, delete,
// modify and display commands.
// ============================================================================
// Each input item carries a command. Insert appends at the tail (status full
// when DEPTH entries are held), delete removes the first equal entry and
// closes the gap, modify overwrites the first equal entry, and display
// streams every entry oldest first with last set on the final one. One item
// is worked on at a time. Insert and the empty-list answers are given from
// the decode state. Delete, modify and display walk the store through its
// single read port, one entry per cycle while the output is not stalled;
// delete overlaps the shift-down of later entries with that same walk. A
// new item is taken once the previous one is finished and the output
// register is free or being drained. The store holds no reset value: only
// entries below the entry count are ever read.
// ============================================================================
`timescale 1ns / 1ps
`include "ordered_value_list_core_defines.svh"

module ordered_value_list_core import ovl_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  // item input
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ovl_in_t  in_item_i,
  // result output
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ovl_out_t out_item_o
);

  ovl_ctl_t  ctl;
  ovl_stat_t stat;
  logic      in_accept;

  // ready only in idle with room for the next result
  assign in_stall_o = !ctl.in_ready;
  assign in_accept  = in_valid_i && ctl.in_ready;

  ovl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  ovl_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_item_i   (in_item_i),
    .ctl_i       (ctl),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // A result must never overwrite one still waiting on the output.
  `OVL_ASSERT(a_res_slot_free, ctl.res_load, stat.out_free, "result loaded into busy output")
  // Insert never grows a full list; delete never shrinks an empty one.
  `OVL_ASSERT(a_no_overfill, ctl.cnt_op == CNT_INC, !stat.full, "count grew past DEPTH")
  `OVL_ASSERT(a_no_underflow, ctl.cnt_op == CNT_DEC, stat.empty == 1'b0, "count dropped below 0")
  // In the cycle after taking an item the block is not ready.
  `OVL_ASSERT_NEXT(a_busy_after_accept, in_accept, !ctl.in_ready, "ready right after accept")

endmodule
